### hw/rtl/mhtq_pkg.sv
// Shared types and constants for the min-heap timer queue.
package mhtq_pkg;
	localparam int Capacity = 32;
	localparam int AddrW = $clog2(Capacity);
	localparam int CountW = $clog2(Capacity + 1);
	localparam int MaxResults = 32;
	localparam int ResCntW = $clog2(MaxResults + 1);
	localparam int EntryW = 8 + 32 + 1;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_CANCEL = 2'd1,
		OP_ADJUST = 2'd2,
		OP_TICK = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] id;
		logic [31:0] expiry;
		logic cancelled;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_FIND_RD,
		S_FIND_CMP,
		S_DN_RDL,
		S_DN_RDR,
		S_DN_CMP,
		S_TICK_RD,
		S_TICK_CHK,
		S_TICK_LAST,
		S_TICK_LASTW,
		S_DONE
	} state_t;
endpackage

### hw/rtl/mhtq_ram.sv
// Generic single-port RAM with registered read.
module mhtq_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] addr,
	input logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

### hw/rtl/min_heap_timer_queue_top.sv
// Binary min-heap timer queue: sequencer over one heap RAM.
// Add climbs level by level from the tail; cancel/adjust search the slots in order,
// and adjust then descends level by level; tick pops and re-sifts once per expired entry.
// One transaction at a time: busy stays high until the last result strobe.
// Results appear on one-cycle strobes; the receiver cannot stall.
// Reset clears the entry count and the sequencer; heap RAM content is not cleared.
module min_heap_timer_queue_top
	import mhtq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] opcode,
	input logic [7:0] timer_id,
	input logic [31:0] expire_time,
	input logic [31:0] now_time,
	output logic strobe,
	output logic [1:0] status,
	output logic fired,
	output logic [7:0] fired_id,
	output logic [5:0] entries_left,
	output logic last
);
	state_t state_q, state_d;
	logic [1:0] op_q;
	logic [7:0] id_q;
	logic [31:0] now_q;
	entry_t cur_q, cur_d;            // entry being sifted
	entry_t lc_q, lc_d;              // left child read
	logic [AddrW:0] pos_q, pos_d;    // hole / search index (one bit wider)
	logic [CountW-1:0] cnt_q, cnt_d;
	logic [ResCntW-1:0] nres_q, nres_d;
	logic [1:0] st_q, st_d;

	logic we;
	logic [AddrW-1:0] addr;
	entry_t wdata, rdata;

	logic out_v, out_f;
	logic [7:0] out_id;
	logic [1:0] out_st;

	mhtq_ram #(.Width(EntryW), .Depth(Capacity)) u_heap (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	logic [AddrW:0] parent, lchild, rchild;
	assign parent = (pos_q - 1'b1) >> 1;
	assign lchild = {pos_q[AddrW-1:0], 1'b1};
	assign rchild = lchild + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q <= opcode;
			id_q <= timer_id;
			now_q <= now_time;
		end
		cur_q <= cur_d;
		lc_q <= lc_d;
		pos_q <= pos_d;
		nres_q <= nres_d;
		st_q <= st_d;
	end

	always_comb begin
		state_d = state_q;
		cur_d = cur_q;
		lc_d = lc_q;
		pos_d = pos_q;
		cnt_d = cnt_q;
		nres_d = nres_q;
		st_d = st_q;
		we = 1'b0;
		addr = pos_q[AddrW-1:0];
		wdata = cur_q;
		out_v = 1'b0;
		out_f = 1'b0;
		out_id = '0;
		out_st = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				st_d = ST_OK;
				nres_d = '0;
				pos_d = '0;
				if (start) begin
					unique case (op_t'(opcode))
						OP_ADD: begin
							if (cnt_q == CountW'(Capacity)) begin
								st_d = ST_FULL;
								state_d = S_DONE;
							end else begin
								cur_d = '{id: timer_id, expiry: expire_time, cancelled: 1'b0};
								pos_d = (AddrW + 1)'(cnt_q);
								cnt_d = cnt_q + 1'b1;
								state_d = S_UP_RD;
							end
						end
						OP_CANCEL, OP_ADJUST: begin
							cur_d.expiry = expire_time;
							state_d = S_FIND_RD;
						end
						OP_TICK: state_d = S_TICK_RD;
					endcase
				end
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					we = 1'b1;
					state_d = S_DONE;
				end else begin
					addr = parent[AddrW-1:0];
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (rdata.expiry <= cur_q.expiry) begin
					we = 1'b1;
					state_d = S_DONE;
				end else begin
					we = 1'b1;
					wdata = rdata;
					pos_d = parent;
					state_d = S_UP_RD;
				end
			end
			S_FIND_RD: begin
				if (pos_q >= (AddrW + 1)'(cnt_q)) begin
					st_d = ST_NOT_FOUND;
					state_d = S_DONE;
				end else
					state_d = S_FIND_CMP;
			end
			S_FIND_CMP: begin
				if (rdata.id == id_q) begin
					if (op_q == OP_CANCEL) begin
						we = 1'b1;
						wdata = rdata;
						wdata.cancelled = 1'b1;
						state_d = S_DONE;
					end else begin
						cur_d = rdata;
						cur_d.expiry = cur_q.expiry;
						state_d = S_DN_RDL;
					end
				end else begin
					pos_d = pos_q + 1'b1;
					state_d = S_FIND_RD;
				end
			end
			S_DN_RDL: begin
				if (lchild >= (AddrW + 1)'(cnt_q)) begin
					we = 1'b1;
					state_d = (op_q == OP_TICK) ? S_TICK_RD : S_DONE;
				end else begin
					addr = lchild[AddrW-1:0];
					state_d = S_DN_RDR;
				end
			end
			S_DN_RDR: begin
				lc_d = rdata;
				addr = rchild[AddrW-1:0];
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (rchild < (AddrW + 1)'(cnt_q) && rdata.expiry < lc_q.expiry) begin
					if (rdata.expiry < cur_q.expiry) begin
						we = 1'b1;
						wdata = rdata;
						pos_d = rchild;
						state_d = S_DN_RDL;
					end else begin
						we = 1'b1;
						state_d = (op_q == OP_TICK) ? S_TICK_RD : S_DONE;
					end
				end else if (lc_q.expiry < cur_q.expiry) begin
					we = 1'b1;
					wdata = lc_q;
					pos_d = lchild;
					state_d = S_DN_RDL;
				end else begin
					we = 1'b1;
					state_d = (op_q == OP_TICK) ? S_TICK_RD : S_DONE;
				end
			end
			S_TICK_RD: begin
				addr = '0;
				pos_d = '0;
				if (cnt_q == '0 || nres_q == ResCntW'(MaxResults))
					state_d = S_DONE;
				else
					state_d = S_TICK_CHK;
			end
			S_TICK_CHK: begin
				if (rdata.expiry <= now_q) begin
					lc_d = rdata;
					cnt_d = cnt_q - 1'b1;
					addr = AddrW'(cnt_q - 1'b1);
					state_d = S_TICK_LAST;
				end else
					state_d = S_DONE;
			end
			S_TICK_LAST: begin
				// lc_q holds popped root; rdata holds former tail entry
				cur_d = rdata;
				if (!lc_q.cancelled) begin
					out_v = 1'b1;
					out_f = 1'b1;
					out_id = lc_q.id;
					nres_d = nres_q + 1'b1;
				end
				state_d = S_TICK_LASTW;
			end
			S_TICK_LASTW: state_d = S_DN_RDL;
			S_DONE: begin
				// tick with results: the held final result goes out here with last set;
				// otherwise a single closing strobe carries the status
				out_v = 1'b1;
				out_st = st_q;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Tick results are held one strobe so that last can mark the final one.
	logic hold_v_q, hold_f_q;
	logic [7:0] hold_id_q;
	logic [5:0] hold_cnt_q;
	logic done_tick;
	assign done_tick = state_q == S_DONE && op_q == OP_TICK && nres_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_v_q <= 1'b0;
		else if (out_v && out_f)
			hold_v_q <= 1'b1;
		else if (done_tick)
			hold_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_v && out_f) begin
			hold_f_q <= 1'b1;
			hold_id_q <= out_id;
			hold_cnt_q <= 6'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
			status <= ST_OK;
			fired <= 1'b0;
			fired_id <= '0;
			entries_left <= '0;
			last <= 1'b0;
		end else begin
			strobe <= 1'b0;
			if (out_v && out_f && hold_v_q) begin
				strobe <= 1'b1;
				status <= ST_OK;
				fired <= hold_f_q;
				fired_id <= hold_id_q;
				entries_left <= hold_cnt_q;
				last <= 1'b0;
			end else if (done_tick) begin
				strobe <= 1'b1;
				status <= ST_OK;
				fired <= 1'b1;
				fired_id <= hold_id_q;
				entries_left <= hold_cnt_q;
				last <= 1'b1;
			end else if (out_v && !out_f) begin
				strobe <= 1'b1;
				status <= out_st;
				fired <= 1'b0;
				fired_id <= '0;
				entries_left <= 6'(cnt_q);
				last <= 1'b1;
			end
		end
	end

	assign busy = state_q != S_IDLE;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CountW'(Capacity)) else $error("entry count overflow");
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q <= ResCntW'(MaxResults)) else $error("result count overflow");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !we) else $error("heap write while idle");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy) else $error("final result while busy");
endmodule

### dv/tb_top.sv
// Testbench for the min-heap timer queue: heap predictor, scoreboard and random stimulus.
module tb_top;
	import mhtq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [1:0] status;
		logic fired;
		logic [7:0] fired_id;
		logic [5:0] entries_left;
		logic last;
	} timer_result_t;

	// Heap predictor plus queue of expected results.
	class timer_scoreboard;
		logic [7:0] heap_id [Capacity];
		logic [31:0] heap_exp [Capacity];
		logic heap_can [Capacity];
		int count;
		timer_result_t pending[$];
		int mismatches;

		function void clear();
			count = 0;
			mismatches = 0;
			pending.delete();
		endfunction

		function void push_result(logic [1:0] st, logic f, logic [7:0] id, logic l);
			timer_result_t r;
			r.status = st;
			r.fired = f;
			r.fired_id = id;
			r.entries_left = count[5:0];
			r.last = l;
			pending.push_back(r);
		endfunction

		function void sink(int pos);
			logic [7:0] id;
			logic [31:0] ex;
			logic cn;
			int c;
			id = heap_id[pos];
			ex = heap_exp[pos];
			cn = heap_can[pos];
			while (2 * pos + 1 < count) begin
				c = 2 * pos + 1;
				if (c + 1 < count && heap_exp[c + 1] < heap_exp[c])
					c++;
				if (heap_exp[c] < ex) begin
					heap_id[pos] = heap_id[c];
					heap_exp[pos] = heap_exp[c];
					heap_can[pos] = heap_can[c];
					pos = c;
				end else begin
					break;
				end
			end
			heap_id[pos] = id;
			heap_exp[pos] = ex;
			heap_can[pos] = cn;
		endfunction

		function void note_command(op_t op, logic [7:0] id, logic [31:0] ex,
				logic [31:0] now);
			int hole;
			int par;
			int pos;
			int n;
			logic [7:0] fid;
			logic live;
			case (op)
				OP_ADD: begin
					if (count >= Capacity) begin
						push_result(ST_FULL, 0, 0, 1);
					end else begin
						hole = count;
						count++;
						while (hole > 0) begin
							par = (hole - 1) / 2;
							if (heap_exp[par] <= ex)
								break;
							heap_id[hole] = heap_id[par];
							heap_exp[hole] = heap_exp[par];
							heap_can[hole] = heap_can[par];
							hole = par;
						end
						heap_id[hole] = id;
						heap_exp[hole] = ex;
						heap_can[hole] = 0;
						push_result(ST_OK, 0, 0, 1);
					end
				end
				OP_CANCEL, OP_ADJUST: begin
					pos = -1;
					for (int i = 0; i < count; i++)
						if (pos < 0 && heap_id[i] == id)
							pos = i;
					if (pos < 0) begin
						push_result(ST_NOT_FOUND, 0, 0, 1);
					end else begin
						if (op == OP_CANCEL) begin
							heap_can[pos] = 1;
						end else begin
							heap_exp[pos] = ex;
							sink(pos);
						end
						push_result(ST_OK, 0, 0, 1);
					end
				end
				default: begin
					n = 0;
					while (count > 0 && n < MaxResults && heap_exp[0] <= now) begin
						fid = heap_id[0];
						live = !heap_can[0];
						count--;
						heap_id[0] = heap_id[count];
						heap_exp[0] = heap_exp[count];
						heap_can[0] = heap_can[count];
						sink(0);
						if (live) begin
							push_result(ST_OK, 1, fid, 0);
							n++;
						end
					end
					if (n == 0)
						push_result(ST_OK, 0, 0, 1);
					else
						pending[$].last = 1;
				end
			endcase
		endfunction

		function void check_result(timer_result_t act);
			timer_result_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result st=%0d f=%0d id=%0d left=%0d last=%0d",
						act.status, act.fired, act.fired_id, act.entries_left, act.last);
				return;
			end
			e = pending.pop_front();
			if (act.status !== e.status || act.fired !== e.fired
					|| act.fired_id !== e.fired_id || act.entries_left !== e.entries_left
					|| act.last !== e.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch exp st=%0d f=%0d id=%0d left=%0d last=%0d",
						e.status, e.fired, e.fired_id, e.entries_left, e.last);
					$display("         act st=%0d f=%0d id=%0d left=%0d last=%0d",
						act.status, act.fired, act.fired_id, act.entries_left, act.last);
				end
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [1:0] opcode = 0;
	logic [7:0] timer_id = 0;
	logic [31:0] expire_time = 0;
	logic [31:0] now_time = 0;
	logic strobe;
	logic [1:0] status;
	logic fired;
	logic [7:0] fired_id;
	logic [5:0] entries_left;
	logic last;

	timer_scoreboard sb = new();
	int idle_pct = 0;
	int cycle_cnt = 0;
	logic [31:0] clock_now = 0;

	always #2 clk = ~clk;

	min_heap_timer_queue_top u_dut (.*);

	always @(posedge clk) begin
		timer_result_t r;
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > 1000000) begin
			$display("FAIL");
			$finish;
		end
		if (arst_n && strobe) begin
			r.status = status;
			r.fired = fired;
			r.fired_id = fired_id;
			r.entries_left = entries_left;
			r.last = last;
			sb.check_result(r);
		end
	end

	// One transaction: wait random idle, raise start, hold until accepted.
	task automatic issue(op_t op, logic [7:0] id, logic [31:0] ex, logic [31:0] now);
		while ($urandom_range(99) < idle_pct)
			@(posedge clk);
		opcode <= op;
		timer_id <= id;
		expire_time <= ex;
		now_time <= now;
		start <= 1;
		do
			@(posedge clk);
		while (busy);
		sb.note_command(op, id, ex, now);
		start <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_item();
		int k;
		logic [7:0] id;
		logic [31:0] ex;
		k = $urandom_range(99);
		id = 8'($urandom_range(15));
		if ($urandom_range(9) == 0)
			id = 8'($urandom);
		ex = clock_now + $urandom_range(60);
		if ($urandom_range(19) == 0)
			ex = $urandom;
		if (k < 45)
			issue(OP_ADD, id, ex, $urandom);
		else if (k < 58)
			issue(OP_CANCEL, id, $urandom, $urandom);
		else if (k < 72)
			issue(OP_ADJUST, id, ex, $urandom);
		else begin
			clock_now = clock_now + $urandom_range(25);
			if ($urandom_range(29) == 0)
				issue(OP_TICK, 8'($urandom), $urandom, 32'hFFFF_FFFF);
			else
				issue(OP_TICK, 8'($urandom), $urandom, clock_now);
		end
	endtask

	initial begin
		sb.clear();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed part
		issue(OP_TICK, 8'hFF, 32'hFFFF_FFFF, 0);
		issue(OP_CANCEL, 8'h05, 0, 0);
		issue(OP_ADJUST, 8'h05, 0, 0);
		issue(OP_ADD, 8'h00, 32'h0000_0000, 0);
		issue(OP_ADD, 8'hFF, 32'hFFFF_FFFF, 0);
		issue(OP_ADD, 8'h07, 32'd10, 0);
		issue(OP_ADD, 8'h07, 32'd10, 0);
		issue(OP_ADD, 8'hAA, 32'd10, 0);
		issue(OP_CANCEL, 8'h07, 0, 0);
		issue(OP_CANCEL, 8'h07, 0, 0);
		issue(OP_ADJUST, 8'h07, 32'd50, 0);
		issue(OP_ADJUST, 8'h00, 32'd5, 0);
		issue(OP_TICK, 0, 0, 32'd9);
		issue(OP_TICK, 0, 0, 32'd10);
		issue(OP_TICK, 0, 0, 32'hFFFF_FFFF);
		// fill past capacity, then drain all at once
		for (int i = 0; i < Capacity + 1; i++)
			issue(OP_ADD, i[7:0], $urandom_range(3), 0);
		issue(OP_CANCEL, 8'd3, 0, 0);
		issue(OP_TICK, 0, 0, 32'd3);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: idle_pct = 0;
				1: idle_pct = 88;
				2: idle_pct = 23;
				default: idle_pct = 0;
			endcase
			for (int i = 0; i < 78; i++)
				random_item();
			drain();
		end
		issue(OP_TICK, 0, 0, 32'hFFFF_FFFF);
		drain();
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
